>>> rtl/core/window_squared_difference_sum_assert.svh
// Assertion macros for the window squared-difference sum RTL, used by wsds_accum.
// Uses the clk and rst names of the including module; no other dependencies.
`ifndef WINDOW_SQUARED_DIFFERENCE_SUM_ASSERT_SVH
`define WINDOW_SQUARED_DIFFERENCE_SUM_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WSDS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WSDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/wsds_pkg.sv
// Package for the window squared-difference sum: sizes, types, register codes.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package wsds_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int CELLS   = WINDOW_MAX - 1;
  localparam int REM_W   = $clog2(WINDOW_MAX);
  localparam int K_W     = 7;
  localparam int SQ_W    = 2 * SAMPLE_BITS;
  localparam int PSUM_W  = SQ_W + $clog2(WINDOW_MAX);
  localparam int STAT_W  = 64;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 2;

  localparam logic [K_W-1:0]    K_RESET       = K_W'(2);
  localparam logic [ADDR_W-1:0] ADDR_WINDOW_K = ADDR_W'(0);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SQ_W-1:0]               sq_t;
  typedef logic [PSUM_W-1:0]             psum_t;
  typedef logic [STAT_W-1:0]             stat_t;
  typedef logic [REM_W-1:0]              rem_t;

  // One transaction as it travels down the chain of cells.
  typedef struct packed {
    logic    v;     // stage holds a transaction
    logic    last;  // final sample of the data set
    logic    keep;  // window of two or more in force for this sample
    rem_t    rem;   // window positions still to compare
    sample_t s;     // the new sample
    sample_t c;     // history value displaced by the previous cell
    logic    cv;    // displaced value is filled
    sq_t     sq;    // square from the previous cell, not yet summed
    psum_t   psum;  // partial sum of earlier squares
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/wsds_cell.sv
// One comparison cell: holds one history entry and one pipeline stage.
// Depends on wsds_pkg.
`default_nettype none

module wsds_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  wsds_pkg::item_t up,
  output wsds_pkg::item_t down
);
  import wsds_pkg::*;

  sample_t                h;
  logic                   hv;
  item_t                  q;
  item_t                  q_next;
  logic                   include_h;
  logic signed [SAMPLE_BITS:0] diff;
  logic [SAMPLE_BITS:0]   mag;
  logic [SAMPLE_BITS-1:0] mag_lo;
  sq_t                    sq_full;

  // Square the distance to the stored entry when it lies inside the window.
  always_comb begin
    include_h = hv && (up.rem != '0);
    diff      = {h[SAMPLE_BITS-1], h} - {up.s[SAMPLE_BITS-1], up.s};
    mag       = diff[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff) : (SAMPLE_BITS+1)'(diff);
    mag_lo    = mag[SAMPLE_BITS-1:0];
    sq_full   = mag_lo * mag_lo;
  end

  always_comb begin
    q_next      = up;
    q_next.rem  = (up.rem != '0) ? up.rem - REM_W'(1) : '0;
    q_next.c    = h;
    q_next.cv   = hv;
    q_next.sq   = include_h ? sq_full : '0;
    q_next.psum = up.psum + PSUM_W'(up.sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.v <= 1'b0;
      hv  <= 1'b0;
    end else if (adv) begin
      q <= q_next;
      // Take the neighbor's entry; drop it when the set ends.
      if (up.v) begin
        hv <= up.cv && !up.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up.v) begin
      h <= up.c;
    end
  end

  assign down = q;

endmodule

`default_nettype wire

>>> rtl/core/wsds_accum.sv
// Running total with saturation and the result register at the chain's end.
// Depends on wsds_pkg and window_squared_difference_sum_assert.svh.
`default_nettype none
`include "window_squared_difference_sum_assert.svh"

module wsds_accum (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  wsds_pkg::item_t  tail,
  output logic            result_valid,
  output wsds_pkg::stat_t  statistic,
  output logic            saturated
);
  import wsds_pkg::*;

  logic        a_v;
  logic        a_last;
  logic        a_keep;
  psum_t       a_sum;
  stat_t       total;
  stat_t       total_next;
  logic        ov;
  logic        ov_next;
  logic [STAT_W:0] wide_sum;

  always_comb begin
    wide_sum   = {1'b0, total} + (STAT_W+1)'(a_sum);
    ov_next    = ov || wide_sum[STAT_W];
    total_next = ov_next ? '1 : wide_sum[STAT_W-1:0];
  end

  // Fold in the last cell's square.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= tail.v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_last <= tail.last;
      a_keep <= tail.keep;
      a_sum  <= tail.psum + PSUM_W'(tail.sq);
    end
  end

  // Accumulate; on the last sample hand out the result and clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      ov           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= a_v && a_last;
      if (a_v) begin
        if (a_last) begin
          total <= '0;
          ov    <= 1'b0;
        end else begin
          total <= total_next;
          ov    <= ov_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_v && a_last) begin
      statistic <= a_keep ? total_next : '0;
      saturated <= a_keep && ov_next;
    end
  end

  `WSDS_ASSERT_IMPL(a_sat_pins_max, ov, total == '1, "saturation flag set below maximum")
  `WSDS_ASSERT_NEXT(a_clear_on_last, adv && a_v && a_last, total == '0 && !ov,
                    "total not cleared after last sample")
  `WSDS_ASSERT_NEXT(a_short_window_zero, adv && a_v && a_last && !a_keep,
                    result_valid && statistic == '0 && !saturated,
                    "short window result not zero")

endmodule

`default_nettype wire

>>> rtl/core/window_squared_difference_sum.sv
// Top level of the window squared-difference sum: register port, chain, total.
// Depends on wsds_pkg, wsds_cell and wsds_accum.
`default_nettype none

// Usage
//   Samples enter on sample/is_last under sample_valid and sample_stall; a
//   transaction completes at a rising edge with valid high and stall low.
//   Send the y values of one data set in ascending x order and mark the final
//   one with is_last. That transaction yields one result transaction on
//   statistic/saturated under result_valid and result_stall; other samples
//   yield none.
//   Datapath: a row of WINDOW_MAX-1 identical cells. Each cell holds one
//   history entry, squares its distance to the passing sample and hands the
//   sample, the displaced entry and the partial sum on to the next cell every
//   cycle that the chain advances; the history therefore shifts along with the wavefront.
//   Throughput: one sample per cycle while the chain is not stalled. The
//   result of a last sample passes one stage per cell, one stage to fold the
//   last square and one for the 64-bit saturating total.
//   Stall: while a result waits under result_stall the whole chain holds and
//   sample_stall is raised; nothing is dropped.
//   Reset: synchronous, active high; empties the chain and history, clears
//   the total and sets window_k to 2. window_k sits at APB address 0 and must be
//   written only while the block is idle; the block itself does not enforce this.
module window_squared_difference_sum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [wsds_pkg::ADDR_W-1:0]        paddr,
  input  logic [wsds_pkg::DATA_W-1:0]        pwdata,
  output logic [wsds_pkg::DATA_W-1:0]        prdata,
  output logic                               pready,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  wsds_pkg::sample_t                  sample,
  input  logic                               is_last,
  output logic                               result_valid,
  input  logic                               result_stall,
  output wsds_pkg::stat_t                    statistic,
  output logic                               saturated
);
  import wsds_pkg::*;

  logic [K_W-1:0] window_k;
  logic           adv;
  rem_t           rem_init;
  item_t          link [CELLS+1];

  // Register port: one register, no wait states.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_WINDOW_K) ? DATA_W'(window_k) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_k <= K_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_K)) begin
      window_k <= pwdata[K_W-1:0];
    end
  end

  // Hold everything while a finished result is not taken.
  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;

  // Clamp the window to the chain length; count positions to compare.
  always_comb begin
    if (window_k > K_W'(WINDOW_MAX)) begin
      rem_init = REM_W'(CELLS);
    end else if (window_k == '0) begin
      rem_init = '0;
    end else begin
      rem_init = REM_W'(window_k - K_W'(1));
    end
  end

  // Head of the chain: the new sample is also the entry pushed into cell 0.
  always_comb begin
    link[0].v    = sample_valid;
    link[0].last = is_last;
    link[0].keep = window_k >= K_W'(2);
    link[0].rem  = rem_init;
    link[0].s    = sample;
    link[0].c    = sample;
    link[0].cv   = 1'b1;
    link[0].sq   = '0;
    link[0].psum = '0;
  end

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    wsds_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .up   (link[g]),
      .down (link[g+1])
    );
  end

  wsds_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .tail         (link[CELLS]),
    .result_valid (result_valid),
    .statistic    (statistic),
    .saturated    (saturated)
  );

endmodule

`default_nettype wire

>>> dv/wsds_score_pkg.sv
// Scoreboard for the window squared-difference sum: predicts one statistic per data set.
// Depends on wsds_pkg for sizes and the sample and statistic types.
package wsds_score_pkg;

  import wsds_pkg::*;

  typedef struct {
    stat_t statistic;
    bit    saturated;
  } set_outcome_t;

  class neighbor_sum_scoreboard;
    logic [K_W-1:0] window_k;
    sample_t        recent [CELLS];
    int unsigned    filled;
    stat_t          running_sum;
    bit             clamped;
    set_outcome_t   expected_sets [$];
    int unsigned    errors;

    function new();
      window_k = K_RESET;
      errors   = 0;
      clear_set();
    endfunction

    function void clear_set();
      foreach (recent[i]) recent[i] = '0;
      filled      = 0;
      running_sum = '0;
      clamped     = 1'b0;
    endfunction

    function void set_window(logic [K_W-1:0] k);
      window_k = k;
    endfunction

    function int unsigned pending();
      return expected_sets.size();
    endfunction

    // Fold one accepted sample into the running sum; queue the outcome on last.
    function void note_sample(sample_t s, bit last);
      int unsigned    span;
      int unsigned    n;
      bit             active;
      int             diff;
      stat_t          mag;
      stat_t          acc;
      set_outcome_t   outcome;
      span   = (window_k > WINDOW_MAX) ? WINDOW_MAX : window_k;
      active = (span >= 2);
      if (active) begin
        n = span - 1;
        if (n > filled) n = filled;
        for (int i = 0; i < n; i++) begin
          diff = int'(recent[i]) - int'(s);
          mag  = (diff < 0) ? stat_t'(-diff) : stat_t'(diff);
          acc  = running_sum + mag * mag;
          if (acc < running_sum) begin
            running_sum = '1;
            clamped     = 1'b1;
          end else begin
            running_sum = acc;
          end
        end
      end
      if (last) begin
        outcome.statistic = active ? running_sum : '0;
        outcome.saturated = active ? clamped : 1'b0;
        expected_sets.push_back(outcome);
        clear_set();
        return;
      end
      for (int i = CELLS - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = s;
      if (filled < CELLS) filled++;
    endfunction

    function void check_result(stat_t statistic, bit saturated);
      set_outcome_t want;
      if (expected_sets.size() == 0) begin
        $error("result transaction with no data set pending: statistic %0d", statistic);
        errors++;
        return;
      end
      want = expected_sets.pop_front();
      if (statistic !== want.statistic) begin
        $error("statistic mismatch: expected %0d, got %0d", want.statistic, statistic);
        errors++;
      end
      if (saturated !== want.saturated) begin
        $error("saturated mismatch: expected %0b, got %0b", want.saturated, saturated);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
// Top-level testbench for window_squared_difference_sum: drives samples and APB writes.
// Depends on wsds_pkg, wsds_score_pkg and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wsds_pkg::*;
  import wsds_score_pkg::*;

  // The chain is 63 cells plus two stages; the drain wait covers them with margin to spare.
  localparam int DRAIN_CYCLES = 70;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1750;

  typedef enum {VAL_ANY, VAL_NEAR, VAL_EDGE} value_mode_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                sample_valid;
  logic                sample_stall;
  sample_t             sample;
  logic                is_last;
  logic                result_valid;
  logic                result_stall;
  stat_t               statistic;
  logic                saturated;

  neighbor_sum_scoreboard sb = new();

  bit          calm;          // no idling on either side while set
  bit          hold_request;  // ask the receiver for one long hold-off
  int unsigned items_sent;

  window_squared_difference_sum DUT (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .statistic    (statistic),
    .saturated    (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Observe both handshakes at the rising edge; inputs only move on the falling edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall) sb.note_sample(sample, is_last);
      if (result_valid && !result_stall) sb.check_result(statistic, saturated);
    end
  end

  // Mostly short runs, now and then a long one.
  function automatic int unsigned pick_run();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: toggle stall in runs; serve a hold-off request with one long stretch,
  // counted here so the sender keeps pushing and the chain backs up.
  initial begin
    int unsigned run_len;
    logic        level;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        level   = 1'b1;
        run_len = HOLD_CYCLES;
      end else if (calm) begin
        level   = 1'b0;
        run_len = 1;
      end else begin
        level   = ($urandom_range(0, 99) < 30);
        run_len = pick_run();
      end
      result_stall <= level;
      repeat (run_len - 1) @(negedge clk);
    end
  end

  function automatic sample_t pick_value(value_mode_t mode, sample_t base);
    case (mode)
      VAL_NEAR: return sample_t'(int'(base) + $urandom_range(0, 16) - 8);
      VAL_EDGE: begin
        case ($urandom_range(0, 6))
          0: return sample_t'(-32768);
          1: return sample_t'(-32767);
          2: return sample_t'(-1);
          3: return sample_t'(0);
          4: return sample_t'(1);
          5: return sample_t'(32766);
          default: return sample_t'(32767);
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Offer one sample transaction and hold it until it is taken.
  task automatic send_sample(input sample_t value, input logic last);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_run();
    if (gap > 0) begin
      @(negedge clk);
      sample_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    sample       <= value;
    is_last      <= last;
    do @(posedge clk); while (sample_stall);
    items_sent++;
  endtask

  // Send len samples of one data set; mark the final one last only when closing.
  task automatic send_set(input int unsigned len, input bit close);
    value_mode_t mode;
    sample_t     base;
    mode = value_mode_t'($urandom_range(0, 2));
    base = sample_t'($urandom);
    for (int i = 0; i < len; i++)
      send_sample(pick_value(mode, base), close && (i == len - 1));
  endtask

  // Drop valid, let every expected result arrive, then let trailing samples clear
  // the chain: they produce nothing the scoreboard could wait on.
  task automatic wait_idle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [K_W-1:0] k);
    logic [DATA_W-1:0] word;
    word = $urandom;
    word[K_W-1:0] = k;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_WINDOW_K;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_window(k);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [K_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return K_W'(0);
      1: return K_W'(1);
      2: return K_W'(2);
      3: return K_W'(64);
      4: return K_W'(127);
      5: return K_W'(65);
      6: return K_W'($urandom_range(3, 8));
      default: return K_W'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic int unsigned pick_set_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 30);
    return $urandom_range(60, 80);
  endfunction

  initial begin
    int unsigned phase;
    int unsigned sets;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample_valid = 1'b0;
    sample       = '0;
    is_last      = 1'b0;
    calm         = 1'b0;
    hold_request = 1'b0;
    items_sent   = 0;
    // Count rising edges so the clock's first transition at time zero is not counted.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset window of two with full-scale swings, then a one-sample set.
    send_sample(sample_t'(32767), 1'b0);
    send_sample(sample_t'(-32768), 1'b0);
    send_sample(sample_t'(32767), 1'b0);
    send_sample(sample_t'(-32768), 1'b1);
    send_sample(sample_t'(0), 1'b1);
    wait_idle();
    // Widest window: every sample against all earlier ones.
    write_window(K_W'(64));
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(32767), 1'b0);
    send_sample(sample_t'(-32768), 1'b1);
    wait_idle();
    // Windows below two yield zero.
    write_window(K_W'(0));
    send_sample(sample_t'(100), 1'b0);
    send_sample(sample_t'(-100), 1'b0);
    send_sample(sample_t'(5), 1'b1);
    wait_idle();
    write_window(K_W'(1));
    send_sample(sample_t'(7), 1'b0);
    send_sample(sample_t'(-7), 1'b1);
    wait_idle();
    // Window beyond the maximum is clipped to the chain length.
    write_window(K_W'(127));
    send_sample(sample_t'(-32768), 1'b0);
    send_sample(sample_t'(32767), 1'b0);
    send_sample(sample_t'(0), 1'b1);
    wait_idle();

    // Random phases. Some phases stop in the middle of a set, so the next window
    // applies to the rest of it. Saturation needs around 2^26 samples in one set,
    // far past this run, so the clamp path is only predicted, never reached.
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      write_window(pick_window());
      if (phase == 3) begin
        // Back-pressure: short sets at full rate while the receiver holds off.
        calm         = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++) send_set($urandom_range(1, 4), 1'b1);
      end else begin
        calm = ($urandom_range(0, 4) == 0);
        sets = $urandom_range(1, 6);
        for (int i = 0; i < sets; i++) send_set(pick_set_len(), 1'b1);
        if ($urandom_range(0, 3) == 0) send_set($urandom_range(1, 10), 1'b0);
      end
      wait_idle();
      phase++;
    end

    // Close any open set so its result is checked too.
    calm = 1'b0;
    send_sample(sample_t'($urandom), 1'b1);
    @(negedge clk);
    sample_valid <= 1'b0;
    repeat (20000) begin
      if (sb.pending() == 0) break;
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d data set results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> window_squared_difference_sum.f
+incdir+rtl/core
rtl/core/wsds_pkg.sv
rtl/core/wsds_cell.sv
rtl/core/wsds_accum.sv
rtl/core/window_squared_difference_sum.sv
dv/wsds_score_pkg.sv
dv/tb_top.sv
